// File: rtl/core/nsmp_pkg.sv
package nsmp_pkg;

    // one table entry as held in the node memory
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] cap;
        logic [31:0] share;
    } t_entry;

    // splitmix64 constants
    localparam logic [63:0] MIX_C1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C2 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C3 = 64'h94D049BB133111EB;
    localparam int unsigned MIX_S1 = 30;
    localparam int unsigned MIX_S2 = 27;
    localparam int unsigned MIX_S3 = 31;

    // pick policies
    localparam logic [1:0] POL_HASH_RR  = 2'd0;
    localparam logic [1:0] POL_LEAST    = 2'd1;
    localparam logic [1:0] POL_WEIGHTED = 2'd2;
    localparam logic [1:0] POL_FAILOVER = 2'd3;

    // item kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;

endpackage

// File: rtl/core/nsmp_hash.sv
module nsmp_hash
    import nsmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_seed,
    output logic        o_done,
    output logic [63:0] o_value
);

    logic        r_busy;
    logic        r_phase;
    logic [1:0]  r_k;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [63:0] r_val;
    logic [63:0] v_add;
    logic [63:0] v_const;
    logic [31:0] v_aop;
    logic [31:0] v_bop;
    logic [63:0] v_prod;

    // 64x64 low product from three 32x32 partial products, one per cycle
    always_comb begin
        v_add   = i_seed + MIX_C1;
        v_const = r_phase ? MIX_C3 : MIX_C2;
        v_aop   = (r_k == 2'd2) ? r_a[63:32] : r_a[31:0];
        v_bop   = (r_k == 2'd1) ? v_const[63:32] : v_const[31:0];
        v_prod  = 64'(v_aop) * 64'(v_bop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a     <= v_add ^ (v_add >> MIX_S1);
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_k     <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                unique case (r_k)
                    2'd0: r_acc <= v_prod;
                    2'd1, 2'd2: r_acc[63:32] <= r_acc[63:32] + v_prod[31:0];
                    default: begin
                        if (!r_phase) begin
                            r_a     <= r_acc ^ (r_acc >> MIX_S2);
                            r_phase <= 1'b1;
                        end else begin
                            r_val  <= r_acc ^ (r_acc >> MIX_S3);
                            r_done <= 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_val;

endmodule

// File: rtl/core/nsmp_div.sv
module nsmp_div #(
    parameter int DVS_W = 37
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [63:0]      r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   v_sh;
    logic [DVS_W:0]   v_diff;

    // restoring remainder, one dividend bit a cycle
    always_comb begin
        v_sh   = {r_rem, r_dvd[63]};
        v_diff = v_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_rem <= v_diff[DVS_W] ? v_sh[DVS_W-1:0] : v_diff[DVS_W-1:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/nsmp_table.sv
module nsmp_table
    import nsmp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry,
    input  logic             i_wr_ready,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_entry,
    output logic             o_rd_ready
);

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_ready;
    t_entry           r_rd;
    logic             r_rd_ready;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        r_rd <= r_mem[i_rd_idx];
    end

    // ready flags clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= '0;
            r_rd_ready <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ready[i_wr_idx] <= i_wr_ready;
            end
            r_rd_ready <= r_ready[i_rd_idx];
        end
    end

    assign o_rd_entry = r_rd;
    assign o_rd_ready = r_rd_ready;

endmodule

// File: rtl/core/node_selector_multi_policy.sv
// node selector: a table of up to MAX_NODES entries (id, ready flag, capacity,
// share weight) picks one node id per pick transfer under the configured
// policy (0 hashed round robin, 1 least connection, 2 weighted random,
// 3 failover) and reports the ready count; write transfers load one entry and
// give no result. one item is worked at a time. a pick scans the used entries
// (up to the clamped node count) through the node memory, and a second scan
// runs if every usable node was the avoided one. hashed round robin and
// weighted random (unless the share total is zero) then run a restoring
// remainder unit (splitmix64 hash overlaps the scan) and a second walk;
// least connection and failover finish right after the scan. the result sits
// in an output register so the next item is taken while it waits
module node_selector_multi_policy
    import nsmp_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, node_id, node_ready, capacity, share_weight, seed, avoid_id
    input  logic [167:0] s_axis_tdata,
    // cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // picked_id, ready_count
    output logic [23:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int TOT_W = 32 + CNT_W;
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // input fields
    logic [3:0]  v_entry_index;
    logic [15:0] v_node_id;
    logic        v_node_ready;
    logic [31:0] v_capacity;
    logic [31:0] v_share;
    logic [63:0] v_seed;
    logic [15:0] v_avoid;

    assign v_entry_index = s_axis_tdata[3:0];
    assign v_node_id     = s_axis_tdata[19:4];
    assign v_node_ready  = s_axis_tdata[20];
    assign v_capacity    = s_axis_tdata[52:21];
    assign v_share       = s_axis_tdata[84:53];
    assign v_seed        = s_axis_tdata[148:85];
    assign v_avoid       = s_axis_tdata[164:149];

    // configuration
    logic [1:0] r_policy;
    logic [4:0] r_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FAILOVER;
            r_count  <= 5'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_POLICY) begin
                r_policy <= i_cfg_data[1:0];
            end else if (i_cfg_index == REG_COUNT) begin
                r_count <= i_cfg_data[4:0];
            end
        end
    end

    // entries in use, clamped to the table size
    logic [CNT_W-1:0] v_lim;
    assign v_lim = (32'(r_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(r_count);

    // sequencer state
    logic [2:0]       r_state;
    logic [15:0]      r_skip;
    logic [CNT_W-1:0] r_iss;
    logic             r_pend;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rc;
    logic [15:0]      r_first;
    logic [TOT_W-1:0] r_total;
    logic             r_hasbest;
    logic [15:0]      r_bestid;
    logic [31:0]      r_bestcap;
    logic [63:0]      r_hval;
    logic             r_hvld;
    logic [TOT_W-1:0] r_dvsr;
    logic [TOT_W-1:0] r_rem;

    // output register
    logic        r_ovld;
    logic [15:0] r_opick;
    logic [4:0]  r_orc;

    logic        v_accept;
    logic        v_wr_en;
    logic [EXT_W-1:0] v_wr_ext;
    t_entry      v_wr_entry;
    t_entry      v_rd;
    logic        v_rd_ready;
    logic        v_usable;
    logic        v_issue;
    logic        v_scan_end;
    logic        v_hash_done;
    logic [63:0] v_hash;
    logic        v_div_start;
    logic        v_div_done;
    logic [TOT_W-1:0] v_div_rem;
    logic        v_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign v_accept      = s_axis_tvalid && s_axis_tready;
    assign v_wr_ext      = EXT_W'(v_entry_index);
    assign v_wr_en       = v_accept && (s_axis_tuser == CMD_WRITE) &&
                           (32'(v_entry_index) < MAX_NODES);
    assign v_wr_entry    = '{id: v_node_id, cap: v_capacity, share: v_share};
    assign v_usable      = v_rd_ready && (v_rd.id != r_skip);
    assign v_issue       = (r_iss < v_lim);
    assign v_scan_end    = !v_issue && !r_pend;
    assign v_div_start   = (r_state == S_HASH) && r_hvld;
    assign v_out_free    = !r_ovld || m_axis_tready;

    nsmp_table #(
        .DEPTH (MAX_NODES),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (v_wr_en),
        .i_wr_idx   (v_wr_ext[IDX_W-1:0]),
        .i_wr_entry (v_wr_entry),
        .i_wr_ready (v_node_ready),
        .i_rd_idx   (r_iss[IDX_W-1:0]),
        .o_rd_entry (v_rd),
        .o_rd_ready (v_rd_ready)
    );

    // hash starts as soon as the pick is taken and overlaps the scan
    nsmp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (v_accept && (s_axis_tuser == CMD_PICK)),
        .i_seed  (v_seed),
        .o_done  (v_hash_done),
        .o_value (v_hash)
    );

    nsmp_div #(
        .DVS_W (TOT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (v_div_start),
        .i_dividend (r_hval),
        .i_divisor  (r_dvsr),
        .o_done     (v_div_done),
        .o_rem      (v_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_hvld  <= 1'b0;
            r_ovld  <= 1'b0;
            r_iss   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_dvsr  <= '1;
        end else begin
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            if (v_hash_done) begin
                r_hval <= v_hash;
                r_hvld <= 1'b1;
            end
            // memory walk pipeline, one entry issued per cycle
            if (r_state == S_SCAN || r_state == S_WALK) begin
                r_pend <= v_issue;
                if (v_issue) begin
                    r_iss <= r_iss + CNT_W'(1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (v_accept && (s_axis_tuser == CMD_PICK)) begin
                        r_state   <= S_SCAN;
                        r_skip    <= v_avoid;
                        r_hvld    <= 1'b0;
                        r_iss     <= '0;
                        r_pend    <= 1'b0;
                        r_cnt     <= '0;
                        r_rc      <= '0;
                        r_first   <= '0;
                        r_total   <= '0;
                        r_hasbest <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        r_rc <= r_rc + CNT_W'(v_rd_ready);
                        if (v_usable) begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_total <= r_total + TOT_W'(v_rd.share);
                            if (r_first == 16'd0) begin
                                r_first <= v_rd.id;
                            end
                            if (!r_hasbest || v_rd.cap > r_bestcap ||
                                (v_rd.cap == r_bestcap && v_rd.id < r_bestid)) begin
                                r_hasbest <= 1'b1;
                                r_bestid  <= v_rd.id;
                                r_bestcap <= v_rd.cap;
                            end
                        end
                    end
                    if (v_scan_end) begin
                        if (r_cnt == '0) begin
                            if (r_skip != 16'd0) begin
                                // every usable node was avoided: scan again with none avoided
                                r_skip    <= 16'd0;
                                r_iss     <= '0;
                                r_rc      <= '0;
                                r_first   <= '0;
                                r_total   <= '0;
                                r_hasbest <= 1'b0;
                            end else begin
                                r_opick <= 16'd0;
                                r_state <= S_DONE;
                            end
                        end else begin
                            unique case (r_policy)
                                POL_HASH_RR: begin
                                    r_dvsr  <= TOT_W'(r_cnt);
                                    r_state <= S_HASH;
                                end
                                POL_LEAST: begin
                                    r_opick <= r_bestid;
                                    r_state <= S_DONE;
                                end
                                POL_WEIGHTED: begin
                                    if (r_total == '0) begin
                                        r_opick <= r_first;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_dvsr  <= r_total;
                                        r_state <= S_HASH;
                                    end
                                end
                                default: begin
                                    r_opick <= r_first;
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_HASH: begin
                    if (r_hvld) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (v_div_done) begin
                        r_rem   <= v_div_rem;
                        r_iss   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_pend && v_usable) begin
                        if (r_policy == POL_HASH_RR) begin
                            if (r_rem == '0) begin
                                r_opick <= v_rd.id;
                                r_state <= S_DONE;
                            end else begin
                                r_rem <= r_rem - TOT_W'(1);
                            end
                        end else if (r_rem < TOT_W'(v_rd.share)) begin
                            r_opick <= v_rd.id;
                            r_state <= S_DONE;
                        end else begin
                            r_rem <= r_rem - TOT_W'(v_rd.share);
                        end
                    end else if (v_scan_end) begin
                        r_opick <= r_first;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (v_out_free) begin
                        r_ovld  <= 1'b1;
                        r_orc   <= 5'(r_rc);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result stays in r_opick until the output register takes it
    logic [15:0] r_outpick;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && v_out_free) begin
            r_outpick <= r_opick;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {3'b000, r_orc, r_outpick};

    // divisor never zero while the remainder unit runs
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvsr != '0))
        else $error("remainder unit started with zero divisor");

    // the walk remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rem < r_dvsr))
        else $error("walk remainder out of range");

    // usable count never exceeds the entries issued so far
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= r_iss))
        else $error("usable count exceeds scanned entries");

    // a finished pick waiting on a full output register does not drop it
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !v_out_free) |=> (r_state == S_DONE))
        else $error("result left before output register was free");

endmodule

// File: verif/node_selector_multi_policy_test.sv
module node_selector_multi_policy_test;
    import nsmp_pkg::*;

    localparam int SEL_LIMIT = 1000000;
    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic        cmd;
        logic [3:0]  idx;
        logic [15:0] id;
        logic        rdy;
        logic [31:0] cap;
        logic [31:0] shr;
        logic [63:0] seed;
        logic [15:0] avoid;
    } t_req;

    typedef struct {
        logic [15:0] picked;
        logic [4:0]  rcount;
    } t_pick;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [167:0]  s_axis_tdata;
    logic          s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [23:0]   m_axis_tdata;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [7:0]    i_cfg_data;

    node_selector_multi_policy u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the node table and registers
    logic [15:0] tbl_id [TABLE_DEPTH];
    logic        tbl_rdy [TABLE_DEPTH];
    logic [31:0] tbl_cap [TABLE_DEPTH];
    logic [31:0] tbl_shr [TABLE_DEPTH];
    logic [1:0]  cur_policy;
    logic [4:0]  cur_count;

    t_req  pending_reqs[$];
    t_pick expected_picks[$];
    int    mismatches;
    int    src_gap;
    int    sink_gap;
    int    sink_hold;
    logic  start_hold;
    logic  no_idle;
    int    cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mix64(logic [63:0] v);
        v = v + 64'h9E3779B97F4A7C15;
        v = (v ^ (v >> 30)) * 64'hBF58476D1CE4E5B9;
        v = (v ^ (v >> 27)) * 64'h94D049BB133111EB;
        return v ^ (v >> 31);
    endfunction

    function automatic int used_count();
        return (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    endfunction

    function automatic logic can_take(int i, logic [15:0] skip);
        return tbl_rdy[i] && tbl_id[i] != skip;
    endfunction

    // one selection pass under the current policy
    function automatic logic [15:0] select_node(logic [63:0] seed, logic [15:0] skip);
        int lim;
        int cnt;
        int best;
        logic [15:0] first;
        logic [63:0] total;
        logic [63:0] r;
        lim = used_count();
        cnt = 0;
        best = -1;
        first = '0;
        total = '0;
        for (int i = 0; i < lim; i++) begin
            if (can_take(i, skip)) begin
                cnt++;
                if (first == 0) first = tbl_id[i];
                total += tbl_shr[i];
            end
        end
        if (cnt == 0) return '0;
        case (cur_policy)
            POL_HASH_RR: begin
                r = mix64(seed) % 64'(cnt);
                for (int i = 0; i < lim; i++) begin
                    if (can_take(i, skip)) begin
                        if (r == 0) return tbl_id[i];
                        r--;
                    end
                end
                return first;
            end
            POL_LEAST: begin
                for (int i = 0; i < lim; i++) begin
                    if (can_take(i, skip) && (best < 0 || tbl_cap[i] > tbl_cap[best] ||
                        (tbl_cap[i] == tbl_cap[best] && tbl_id[i] < tbl_id[best])))
                        best = i;
                end
                return tbl_id[best];
            end
            POL_WEIGHTED: begin
                if (total == 0) return first;
                r = mix64(seed) % total;
                for (int i = 0; i < lim; i++) begin
                    if (can_take(i, skip)) begin
                        if (r < 64'(tbl_shr[i])) return tbl_id[i];
                        r -= 64'(tbl_shr[i]);
                    end
                end
                return first;
            end
            default: return first;
        endcase
    endfunction

    // applies one accepted transfer to the shadow table, queues a pick result
    task automatic predict_pick(t_req q);
        t_pick p;
        int lim;
        logic any;
        if (q.cmd == CMD_WRITE) begin
            tbl_id[q.idx] = q.id;
            tbl_rdy[q.idx] = q.rdy;
            tbl_cap[q.idx] = q.cap;
            tbl_shr[q.idx] = q.shr;
            return;
        end
        lim = used_count();
        p.rcount = '0;
        any = 1'b0;
        for (int i = 0; i < lim; i++) begin
            if (tbl_rdy[i]) p.rcount++;
            if (can_take(i, q.avoid)) any = 1'b1;
        end
        p.picked = select_node(q.seed, q.avoid);
        // everyone usable was the avoided node: retry avoiding nothing
        if (p.picked == 0 && q.avoid != 0 && !any) p.picked = select_node(q.seed, '0);
        expected_picks.push_back(p);
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // driver: feeds pending transfers, one nonblocking update per signal per edge
    always @(posedge i_clk) begin
        t_req q;
        logic vld;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            vld = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                q.cmd = s_axis_tuser;
                {q.avoid, q.seed, q.shr, q.cap, q.rdy, q.id, q.idx} = s_axis_tdata[164:0];
                predict_pick(q);
                vld = 1'b0;
            end
            if (!vld) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    q = pending_reqs.pop_front();
                    s_axis_tuser <= q.cmd;
                    s_axis_tdata <= {3'b000, q.avoid, q.seed, q.shr, q.cap, q.rdy, q.id, q.idx};
                    vld = 1'b1;
                    src_gap <= draw_gap();
                end
            end
            s_axis_tvalid <= vld;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) sink_hold <= 0;
        else if (start_hold) sink_hold <= 600;
        else if (sink_hold > 0) sink_hold <= sink_hold - 1;
    end

    // monitor: checks each result transfer against the oldest expected pick
    always @(posedge i_clk) begin
        t_pick e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_picks.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    e = expected_picks.pop_front();
                    if (m_axis_tdata[15:0] !== e.picked || m_axis_tdata[20:16] !== e.rcount)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected id %h count %0d, got id %h count %0d",
                                e.picked, e.rcount, m_axis_tdata[15:0], m_axis_tdata[20:16]);
                        mismatches++;
                    end
                end
                sink_gap <= draw_gap();
                m_axis_tready <= 1'b0;
            end else if (sink_hold > 0 || start_hold) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == SEL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_POLICY) cur_policy = val[1:0];
        else cur_count = val[4:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_write(logic [3:0] idx, logic [15:0] id, logic rdy,
                              logic [31:0] cap, logic [31:0] shr);
        t_req q;
        q = '{CMD_WRITE, idx, id, rdy, cap, shr, {$urandom, $urandom}, 16'($urandom)};
        pending_reqs.push_back(q);
    endtask

    task automatic push_pick(logic [63:0] seed, logic [15:0] avoid);
        t_req q;
        q = '{CMD_PICK, 4'($urandom), 16'($urandom), 1'($urandom), $urandom, $urandom,
              seed, avoid};
        pending_reqs.push_back(q);
    endtask

    // sender waits until every pick has come back, then lets the block settle
    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_picks.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pool_id();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    initial begin
        int total;
        int nw;
        int np;
        int k;
        logic [31:0] cap;
        logic [31:0] shr;
        logic [15:0] av;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_WRITE;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_POLICY;
        i_cfg_data = '0;
        start_hold = 1'b0;
        no_idle = 1'b0;
        mismatches = 0;
        cycles = 0;
        cur_policy = POL_FAILOVER;
        cur_count = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_id[i] = '0;
            tbl_rdy[i] = 1'b0;
            tbl_cap[i] = '0;
            tbl_shr[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: failover over an empty table
        push_pick('0, '0);
        drain();

        // entry with id zero, extreme ids, capacities and shares
        cfg_write(REG_COUNT, 8'd4);
        push_write(4'd0, 16'h0000, 1'b1, 32'hFFFFFFFF, 32'h0);
        push_write(4'd1, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_write(4'd2, 16'h0005, 1'b0, 32'h0, 32'h0);
        push_write(4'd3, 16'h0007, 1'b1, 32'hFFFFFFFF, 32'h1);
        push_write(4'd15, 16'h0009, 1'b1, 32'h0, 32'h0);
        push_pick('0, '0);
        push_pick('1, 16'hFFFF);
        drain();
        for (int p = 0; p < 3; p++) begin
            cfg_write(REG_POLICY, 8'(p));
            push_pick('0, '0);
            push_pick('1, 16'hFFFF);
            push_pick(64'h0123456789ABCDEF, 16'h0007);
            drain();
        end
        drain();
        // node count above the table size, and sole ready node avoided
        cfg_write(REG_COUNT, 8'd31);
        push_pick('1, 16'h0009);
        drain();
        cfg_write(REG_COUNT, 8'd16);
        cfg_write(REG_POLICY, 8'(POL_HASH_RR));
        push_write(4'd0, 16'h0000, 1'b0, 32'h0, 32'h0);
        push_write(4'd1, 16'h0003, 1'b0, 32'h0, 32'h0);
        push_write(4'd3, 16'h0003, 1'b0, 32'h0, 32'h0);
        push_pick('1, 16'h0009);
        push_pick('0, 16'h0000);
        drain();

        total = 25;
        k = 0;
        while (total < 1100) begin
            cfg_write(REG_POLICY, 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0) cfg_write(REG_COUNT, 8'($urandom_range(0, 31)));
            else cfg_write(REG_COUNT, 8'($urandom_range(1, 16)));
            no_idle = ($urandom_range(0, 4) == 0);
            nw = $urandom_range(1, 16);
            np = $urandom_range(5, 40);
            for (int i = 0; i < nw; i++) begin
                cap = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
                case ($urandom_range(0, 2))
                    0: shr = '0;
                    1: shr = 32'($urandom_range(0, 9));
                    default: shr = $urandom;
                endcase
                push_write(4'($urandom_range(0, 15)), pool_id(),
                           ($urandom_range(0, 3) != 0), cap, shr);
            end
            for (int i = 0; i < np; i++) begin
                case ($urandom_range(0, 9))
                    0: av = 16'($urandom);
                    1, 2, 3, 4: av = 16'($urandom_range(1, 6));
                    default: av = '0;
                endcase
                push_pick({$urandom, $urandom}, av);
            end
            // one phase with the receiver held off while the sender keeps offering
            if (k == 3) begin
                @(posedge i_clk);
                start_hold <= 1'b1;
                @(posedge i_clk);
                start_hold <= 1'b0;
            end
            total += nw + np;
            k++;
            drain();
        end

        if (mismatches == 0 && expected_picks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
